// ===== hdl/agef_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agef_pkg
// Shared types and constants of the adaptive gain smoothing filter: register
// indexes, Q0.16 gain table and register reset values.
// ---------------------------------------------------------------------------
package agef_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int TIME_W    = 32;
    localparam int GAP_W     = 16;
    localparam int LIMIT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_GAP     = 3'd0,
        CFG_LIMIT_HUGE  = 3'd1,
        CFG_LIMIT_LARGE = 3'd2,
        CFG_LIMIT_MED   = 3'd3,
        CFG_LIMIT_SMALL = 3'd4,
        CFG_LIMIT_TINY  = 3'd5,
        CFG_LIMIT_LEAST = 3'd6
    } agef_cfg_idx_t;

    // gains in unsigned Q0.16
    localparam logic [GAIN_W-1:0] GAIN_095  = 16'd62259;
    localparam logic [GAIN_W-1:0] GAIN_080  = 16'd52429;
    localparam logic [GAIN_W-1:0] GAIN_040  = 16'd26214;
    localparam logic [GAIN_W-1:0] GAIN_020  = 16'd13107;
    localparam logic [GAIN_W-1:0] GAIN_010  = 16'd6554;
    localparam logic [GAIN_W-1:0] GAIN_005  = 16'd3277;
    localparam logic [GAIN_W-1:0] GAIN_0025 = 16'd1638;

    localparam logic [GAP_W-1:0]   RST_MIN_GAP     = 16'd1;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_HUGE  = 8'd250;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_LARGE = 8'd75;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_MED   = 8'd25;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_SMALL = 8'd10;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_TINY  = 8'd5;
    localparam logic [LIMIT_W-1:0] RST_LIMIT_LEAST = 8'd2;

    typedef struct packed {
        logic [LIMIT_W-1:0] huge;
        logic [LIMIT_W-1:0] large_lim;
        logic [LIMIT_W-1:0] med;
        logic [LIMIT_W-1:0] small_lim;
        logic [LIMIT_W-1:0] tiny;
        logic [LIMIT_W-1:0] least;
    } agef_limits_t;

endpackage

// ===== hdl/adaptive_gain_ema_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adaptive_gain_ema_filter
// Multi-channel exponential smoothing filter with a gain that adapts to the
// size of each step, gated by a shared millisecond timer.
// ---------------------------------------------------------------------------
// The block takes one beat per clock unless the output stalls or a same-channel
// update ahead holds it, and returns one beat per input beat, in order; each
// beat passes the decision, multiply and round stages and the output register. The
// smoothed values live in a small RAM that is read on acceptance and written
// back from the round stage; a beat whose channel has an update still in the
// multiply or round stages waits until that write has happened. Gain and
// timer are shared by all channels and are settled in the decision stage, so
// they never hold the stream. Beats on alternating channels still wait when
// the update two beats ahead, in the round stage, is on the same channel.
// Configuration writes are accepted in every cycle and must be made while
// the filter is idle.
// ---------------------------------------------------------------------------
module adaptive_gain_ema_filter
    import agef_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // sample[15:0], now_ms[47:16]
    input  logic                  s_tuser,   // channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // filtered[15:0]
    output logic                  m_tuser,   // updated
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int STEP_W = PROD_W + 1 - GAIN_W;
    localparam int SUM_W  = STEP_W + 1;

    // configuration
    logic [GAP_W-1:0] min_gap_reg;
    agef_limits_t     limits_reg;

    // shared state
    logic [GAIN_W-1:0] gain_reg;
    logic [TIME_W-1:0] last_ms_reg;
    logic [CHANNELS-1:0] vld_reg;

    // decision stage
    logic                       b_valid_reg;
    logic signed [SAMPLE_W-1:0] b_sample_reg;
    logic [CH_W-1:0]            b_ch_reg;
    logic [TIME_W-1:0]          b_now_reg;

    // multiply stage
    logic                       c_valid_reg;
    logic                       c_upd_reg;
    logic [CH_W-1:0]            c_ch_reg;
    logic signed [SAMPLE_W-1:0] c_cur_reg;
    logic signed [DIFF_W-1:0]   c_diff_reg;
    logic [GAIN_W-1:0]          c_gain_reg;

    // round stage
    logic                       d_valid_reg;
    logic                       d_upd_reg;
    logic [CH_W-1:0]            d_ch_reg;
    logic signed [SAMPLE_W-1:0] d_cur_reg;
    logic signed [PROD_W-1:0]   d_prod_reg;

    // output
    logic                o_valid_reg;
    logic [SAMPLE_W-1:0] o_data_reg;
    logic                o_upd_reg;

    // write-back bypass
    logic                       wrl_valid_reg;
    logic [CH_W-1:0]            wrl_ch_reg;
    logic signed [SAMPLE_W-1:0] wrl_data_reg;

    logic o_ready, d_adv, d_ready, c_ready, hazard, b_go, s_acc;
    logic [CH_W-1:0]            s_ch;
    logic [CH_W-1:0]            rd_addr;
    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          absd;
    logic [LIMIT_W-1:0]         mag;
    logic [TIME_W-1:0]          elapsed;
    logic                       upd;
    logic [GAIN_W-1:0]          gain_next;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W:0]     rsum;
    logic signed [STEP_W-1:0]   step;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] sat;
    logic signed [SAMPLE_W-1:0] d_next;
    logic                       wr_en;

    // handshake chain
    assign o_ready  = !o_valid_reg || m_tready;
    assign d_adv    = d_valid_reg && o_ready;
    assign d_ready  = !d_valid_reg || o_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign hazard   = (c_valid_reg && c_upd_reg && (c_ch_reg == b_ch_reg))
                   || (d_valid_reg && d_upd_reg && (d_ch_reg == b_ch_reg));
    assign b_go     = b_valid_reg && c_ready && !hazard;
    assign s_tready = !b_valid_reg || b_go;
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign s_ch    = (CHANNELS > 1) ? CH_W'(s_tuser) : '0;
    assign rd_addr = s_acc ? s_ch : b_ch_reg;

    agef_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CHANNELS),
        .ADDR_W(CH_W)
    ) u_value_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(d_ch_reg),
        .wr_data(d_next),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // decision stage logic
    always_comb
    begin
        if (wrl_valid_reg && (wrl_ch_reg == b_ch_reg))
        begin
            cur = wrl_data_reg;
        end
        else if (vld_reg[b_ch_reg])
        begin
            cur = $signed(rd_data);
        end
        else
        begin
            cur = '0;
        end
        diff    = $signed({b_sample_reg[SAMPLE_W-1], b_sample_reg})
                - $signed({cur[SAMPLE_W-1], cur});
        absd    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag     = (|absd[DIFF_W-1:12]) ? {LIMIT_W{1'b1}} : absd[11:4];
        elapsed = b_now_reg - last_ms_reg;
        upd     = elapsed > TIME_W'(min_gap_reg);
    end

    always_comb
    begin
        if (mag > limits_reg.huge)
        begin
            gain_next = GAIN_095;
        end
        else if (mag > limits_reg.large_lim)
        begin
            gain_next = GAIN_080;
        end
        else if (mag > limits_reg.med)
        begin
            gain_next = GAIN_040;
        end
        else if (mag > limits_reg.small_lim)
        begin
            gain_next = GAIN_020;
        end
        else if (mag > limits_reg.tiny)
        begin
            gain_next = GAIN_010;
        end
        else if (mag > limits_reg.least)
        begin
            gain_next = GAIN_005;
        end
        else if (mag != '0)
        begin
            gain_next = GAIN_0025;
        end
        else
        begin
            gain_next = gain_reg;
        end
    end

    // multiply stage logic
    assign prod_next = c_diff_reg * $signed({1'b0, c_gain_reg});

    // round stage logic, ties toward plus infinity
    always_comb
    begin
        rsum = $signed({d_prod_reg[PROD_W-1], d_prod_reg})
             + $signed((PROD_W + 1)'(32768));
        step = rsum[PROD_W:GAIN_W];
        sum  = $signed({{(SUM_W - SAMPLE_W){d_cur_reg[SAMPLE_W-1]}}, d_cur_reg})
             + $signed({step[STEP_W-1], step});
        if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1)
        begin
            sat = sum[SAMPLE_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        d_next = d_upd_reg ? sat : d_cur_reg;
    end

    assign wr_en = d_adv && d_upd_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg          <= RST_MIN_GAP;
            limits_reg.huge      <= RST_LIMIT_HUGE;
            limits_reg.large_lim <= RST_LIMIT_LARGE;
            limits_reg.med       <= RST_LIMIT_MED;
            limits_reg.small_lim <= RST_LIMIT_SMALL;
            limits_reg.tiny      <= RST_LIMIT_TINY;
            limits_reg.least     <= RST_LIMIT_LEAST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (agef_cfg_idx_t'(cfg_index))
                CFG_MIN_GAP:     min_gap_reg          <= cfg_data;
                CFG_LIMIT_HUGE:  limits_reg.huge      <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_LARGE: limits_reg.large_lim <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_MED:   limits_reg.med       <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_SMALL: limits_reg.small_lim <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_TINY:  limits_reg.tiny      <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_LEAST: limits_reg.least     <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
            wrl_valid_reg <= 1'b0;
            vld_reg       <= '0;
            gain_reg      <= '0;
            last_ms_reg   <= '0;
        end
        else
        begin
            if (s_acc)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_go)
            begin
                b_valid_reg <= 1'b0;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_go;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= d_valid_reg;
            end
            wrl_valid_reg <= wr_en;
            if (wr_en)
            begin
                vld_reg[d_ch_reg] <= 1'b1;
            end
            if (b_go && upd)
            begin
                gain_reg    <= gain_next;
                last_ms_reg <= b_now_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            b_sample_reg <= $signed(s_tdata[15:0]);
            b_now_reg    <= s_tdata[47:16];
            b_ch_reg     <= s_ch;
        end
        if (c_ready)
        begin
            c_upd_reg  <= upd;
            c_ch_reg   <= b_ch_reg;
            c_cur_reg  <= cur;
            c_diff_reg <= diff;
            c_gain_reg <= gain_next;
        end
        if (d_ready)
        begin
            d_upd_reg  <= c_upd_reg;
            d_ch_reg   <= c_ch_reg;
            d_cur_reg  <= c_cur_reg;
            d_prod_reg <= prod_next;
        end
        if (o_ready)
        begin
            o_data_reg <= d_next;
            o_upd_reg  <= d_upd_reg;
        end
        if (wr_en)
        begin
            wrl_ch_reg   <= d_ch_reg;
            wrl_data_reg <= d_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_upd_reg;

endmodule

// ===== hdl/agef_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agef_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module agef_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/sv/adaptive_gain_ema_filter_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adaptive_gain_ema_filter_test
// Self-checking bench for the adaptive gain smoothing filter. Sample beats
// are driven with random gaps and the result stream is stalled at random.
// A tracker predicts each filtered value and update flag from its own copy
// of the smoothed levels, gain, timer and registers, and compares every
// result beat in order. Several register settings are run, extremes included.
// ---------------------------------------------------------------------------
module adaptive_gain_ema_filter_test;
    import agef_pkg::*;

    localparam int CHAN = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 250;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam agef_cfg_idx_t LIMIT_IDX [6] = '{CFG_LIMIT_HUGE, CFG_LIMIT_LARGE,
        CFG_LIMIT_MED, CFG_LIMIT_SMALL, CFG_LIMIT_TINY, CFG_LIMIT_LEAST};

    typedef struct {
        logic signed [SAMPLE_W-1:0] level;
        logic                       stepped;
    } smooth_res_t;

    class ema_tracker;
        logic [GAP_W-1:0]           min_gap;
        logic [LIMIT_W-1:0]         limits [6];
        logic signed [SAMPLE_W-1:0] levels [CHAN];
        logic [GAIN_W-1:0]          gain;
        logic [TIME_W-1:0]          last_ms;
        smooth_res_t                expected_q [$];
        int                         errors;

        function new();
            min_gap = RST_MIN_GAP;
            limits = '{RST_LIMIT_HUGE, RST_LIMIT_LARGE, RST_LIMIT_MED,
                       RST_LIMIT_SMALL, RST_LIMIT_TINY, RST_LIMIT_LEAST};
            foreach (levels[c])
                levels[c] = '0;
            gain = '0;
            last_ms = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_GAP:     min_gap = data;
                CFG_LIMIT_HUGE:  limits[0] = data[LIMIT_W-1:0];
                CFG_LIMIT_LARGE: limits[1] = data[LIMIT_W-1:0];
                CFG_LIMIT_MED:   limits[2] = data[LIMIT_W-1:0];
                CFG_LIMIT_SMALL: limits[3] = data[LIMIT_W-1:0];
                CFG_LIMIT_TINY:  limits[4] = data[LIMIT_W-1:0];
                CFG_LIMIT_LEAST: limits[5] = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [GAIN_W-1:0] pick_gain(int mag);
            if (mag > limits[0]) return GAIN_095;
            if (mag > limits[1]) return GAIN_080;
            if (mag > limits[2]) return GAIN_040;
            if (mag > limits[3]) return GAIN_020;
            if (mag > limits[4]) return GAIN_010;
            if (mag > limits[5]) return GAIN_005;
            return GAIN_0025;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s, logic ch,
                                  logic [TIME_W-1:0] t);
            smooth_res_t      r;
            logic [TIME_W-1:0] elapsed;
            int               diff;
            int               mag;
            longint           prod;
            longint           nxt;
            elapsed = t - last_ms;
            r.level = levels[ch];
            r.stepped = 1'b0;
            if (elapsed > min_gap)
            begin
                diff = int'(s) - int'(levels[ch]);
                mag = (diff < 0 ? -diff : diff) >> 4;
                if (mag > 255)
                    mag = 255;
                if (mag != 0)
                    gain = pick_gain(mag);
                prod = longint'(diff) * longint'(gain);
                nxt = longint'(levels[ch]) + ((prod + 64'sd32768) >>> 16);
                if (nxt > 32767)
                    nxt = 32767;
                if (nxt < -32768)
                    nxt = -32768;
                levels[ch] = SAMPLE_W'(nxt);
                last_ms = t;
                r.level = levels[ch];
                r.stepped = 1'b1;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] lv, logic st);
            smooth_res_t r;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: filtered %0d updated %0b", lv, st);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (lv !== r.level)
            begin
                $error("filtered: expected %0d, got %0d", r.level, lv);
                errors++;
            end
            if (st !== r.stepped)
            begin
                $error("updated: expected %0b, got %0b", r.stepped, st);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ema_tracker        ema = new();
    logic [TIME_W-1:0] stamp;
    bit                bursts_on;
    bit                hold_req;
    int                cycles;

    adaptive_gain_ema_filter #(
        .CHANNELS(CHAN)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[adaptive_gain_ema_filter] ERROR");
            $finish;
        end
    end

    // beat monitors
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                ema.note_sample(s_tdata[15:0], s_tuser, s_tdata[47:16]);
            if (m_tvalid && m_tready)
                ema.check_result(m_tdata, m_tuser);
        end
    end

    // result side: random stall bursts and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic ch,
                               input logic [TIME_W-1:0] t);
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t, s};
        s_tuser <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_filter();
        s_tvalid <= 1'b0;
        while (ema.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ema.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [GAP_W-1:0] gap, input logic [LIMIT_W-1:0] lims [6]);
        write_reg(CFG_MIN_GAP, gap);
        foreach (lims[i])
            write_reg(LIMIT_IDX[i], {8'($urandom), lims[i]});
        write_reg(CFG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic next_stamp();
        logic [TIME_W-1:0] g;
        g = ema.min_gap;
        case ($urandom_range(0, 9))
            0: ;
            1: stamp = stamp + g;
            2: stamp = stamp + g + 1;
            3: stamp = $urandom;
            default: stamp = stamp + $urandom_range(0, 2 * g + 2);
        endcase
    endtask

    function automatic logic signed [SAMPLE_W-1:0] make_sample(logic ch);
        int cur;
        int v;
        int d;
        cur = ema.levels[ch];
        case ($urandom_range(0, 7))
            0: v = $signed(16'($urandom));
            1: v = $urandom_range(0, 1) ? 32767 : -32768;
            2:
            begin
                d = $urandom_range(0, 15);
                v = $urandom_range(0, 1) ? cur - d : cur + d;
            end
            default:
            begin
                d = 16 * ema.limits[$urandom_range(0, 5)] + $urandom_range(0, 31);
                v = $urandom_range(0, 1) ? cur - d : cur + d;
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SAMPLE_W'(v);
    endfunction

    task automatic run_random(input int n);
        logic ch;
        repeat (n)
        begin
            ch = $urandom_range(0, 1);
            next_stamp();
            send_sample(make_sample(ch), ch, stamp);
        end
    endtask

    initial
    begin
        int                 mags [9];
        int                 cur;
        logic               ch;
        logic [LIMIT_W-1:0] lims [6];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_GAP;
        cfg_data = '0;
        bursts_on = 1'b0;
        hold_req = 1'b0;
        cycles = 0;
        stamp = '0;
        mags = '{300, 251, 76, 26, 11, 6, 3, 1, 0};
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // timer held, zero step with zero gain, full-scale steps
        send_sample(16'sd100, 1'b0, 32'd0);
        send_sample(16'sd5, 1'b0, 32'd2);
        send_sample(16'sh7fff, 1'b0, 32'd4);
        send_sample(16'sh8000, 1'b1, 32'd6);
        send_sample(16'sd0, 1'b1, 32'd7);
        stamp = 32'd7;
        // one step for each gain, then a zero step that keeps the gain
        foreach (mags[i])
        begin
            ch = i[0];
            cur = ema.levels[ch];
            stamp = stamp + 2;
            send_sample(SAMPLE_W'(cur > 0 ? cur - 16 * mags[i] : cur + 16 * mags[i]), ch,
                        stamp);
        end
        // timer wrap
        send_sample(16'sd1000, 1'b0, 32'hffff_fffe);
        send_sample(16'sd2000, 1'b1, 32'hffff_ffff);
        send_sample(-16'sd2000, 1'b1, 32'd1);
        stamp = 32'd1;

        bursts_on = 1'b1;
        run_random(110);

        drain_filter();
        configure(16'd0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        run_random(90);

        drain_filter();
        configure(16'hffff, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
        run_random(90);

        // limits in reverse order
        drain_filter();
        configure(16'($urandom_range(0, 8)),
                  '{8'd3, 8'd8, 8'd20, 8'd60, 8'd120, 8'd200});
        run_random(110);

        drain_filter();
        foreach (lims[i])
            lims[i] = 8'($urandom);
        configure(16'($urandom_range(0, 20)), lims);
        stamp = 32'hffff_f000;
        run_random(40);
        hold_req = 1'b1;
        run_random(80);

        drain_filter();
        configure(RST_MIN_GAP, '{RST_LIMIT_HUGE, RST_LIMIT_LARGE, RST_LIMIT_MED,
                                 RST_LIMIT_SMALL, RST_LIMIT_TINY, RST_LIMIT_LEAST});
        bursts_on = 1'b0;
        run_random(110);

        drain_filter();
        repeat (20) @(negedge clk);
        if (ema.errors == 0)
            $display("[adaptive_gain_ema_filter] OK");
        else
            $display("[adaptive_gain_ema_filter] ERROR");
        $finish;
    end

endmodule

// ===== adaptive_gain_ema_filter.f =====
hdl/agef_pkg.sv
hdl/agef_ram.sv
hdl/adaptive_gain_ema_filter.sv
tb/sv/adaptive_gain_ema_filter_test.sv
